// ===== src/jkut_pkg.sv =====
// Package for the JIS X0201 / UTF-8 halfwidth transcoder.
// Holds mode codes, sequence phase type, byte constants and the result bundle.
// No dependencies.
package jkut_pkg;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_ENC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  localparam logic [2:0] REG_MODE_IDX = 3'd0;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam logic [7:0] B_KANA_LO  = 8'hA1;
  localparam logic [7:0] B_KANA_HI  = 8'hBF;
  localparam logic [7:0] B_KANA2_LO = 8'hC0;
  localparam logic [7:0] B_KANA2_HI = 8'hDF;
  localparam logic [7:0] B_LEAD     = 8'hEF;
  localparam logic [7:0] B_ROW_BD   = 8'hBD;
  localparam logic [7:0] B_ROW_BE   = 8'hBE;
  localparam logic [7:0] B_ROW_BF   = 8'hBF;
  localparam logic [7:0] B_SHIFT    = 8'h40;
  localparam logic [7:0] B_YEN      = 8'h5C;
  localparam logic [7:0] B_YEN_U8   = 8'hD5;
  localparam logic [7:0] B_OVER     = 8'h7E;
  localparam logic [7:0] B_OVER_U8  = 8'hA3;
  localparam logic [7:0] B_PRINT_LO = 8'h20;
  localparam logic [7:0] B_PRINT_HI = 8'h7F;
  localparam logic [7:0] B_CONT_LO  = 8'h80;
  localparam logic [7:0] B_CONT_HI  = 8'h9F;

  // Results produced by one input item, entry 0 goes out first.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            byte_valid;
    logic            bad;
    logic            last;
  } res_t;

endpackage

// ===== src/jis_katakana_utf8_transcoder_unit.sv =====
// Top level of the JIS X0201 / UTF-8 halfwidth transcoder.
// Holds the mode register and APB port, joins jkut_core and jkut_emit.
// Depends on jkut_pkg, jkut_core, jkut_emit.
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] source byte, tlast end of string
//  out_    | master    | tdata[7:0] byte, tuser {bad_string, byte_valid}, tlast
//  cfg_    | APB slave | mode register at address 0
//
// An item is transcoded in the cycle it is accepted and its results go out
// one byte per cycle while out_tready is high, from a single result
// register that holds the whole bundle of one item.
// The next item is taken in the cycle the final result of the previous one
// leaves. Reset is synchronous and clears the mode and all string state.
module jis_katakana_utf8_transcoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] bad_string
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import jkut_pkg::*;

  logic [1:0] mode_r, mode_nxt;
  logic       fire;
  logic       can_load;
  logic       sel_mode;
  res_t       res;

  assign cfg_pready = 1'b1;
  assign sel_mode   = ({cfg_paddr[2], 2'b00} == REG_MODE_IDX);
  assign cfg_prdata = sel_mode ? {30'd0, mode_r} : 32'd0;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_mode) begin
      mode_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign in_tready = can_load;
  assign fire      = in_tvalid & in_tready;

  jkut_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .fire    (fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .res     (res)
  );

  jkut_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/jkut_core.sv =====
// Transcoding logic and per-string state (sticky error, sequence phase).
// Turns one accepted byte into a bundle of up to three results.
// Depends on jkut_pkg.
module jkut_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       mode,
  input  logic             fire,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output jkut_pkg::res_t   res
);
  import jkut_pkg::*;

  logic       err_r, err_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] second_r, second_nxt;

  logic       ok;
  logic       err_now;
  logic [1:0] n;
  logic [2:0][7:0] b;
  phase_t     ph_step;
  logic [7:0] sb_step;

  always_comb begin
    ok      = 1'b1;
    n       = 2'd0;
    b       = '0;
    ph_step = phase_r;
    sb_step = second_r;
    if (!err_r) begin
      case (mode)
        MODE_ENC: begin
          if (in_byte >= B_KANA_LO && in_byte <= B_KANA_HI) begin
            b = {in_byte, B_ROW_BD, B_LEAD};
            n = 2'd3;
          end else if (in_byte >= B_KANA2_LO && in_byte <= B_KANA2_HI) begin
            b = {in_byte - B_SHIFT, B_ROW_BE, B_LEAD};
            n = 2'd3;
          end else if (in_byte == B_YEN) begin
            b = {B_YEN_U8, B_ROW_BF, B_LEAD};
            n = 2'd3;
          end else if (in_byte == B_OVER) begin
            b = {B_OVER_U8, B_ROW_BF, B_LEAD};
            n = 2'd3;
          end else if (in_byte >= B_PRINT_LO && in_byte <= B_PRINT_HI) begin
            b[0] = in_byte;
            n    = 2'd1;
          end else begin
            ok = 1'b0;
          end
        end
        MODE_DEC: begin
          unique case (phase_r)
            PH_LEAD: begin
              if (in_byte == B_LEAD) begin
                ph_step = PH_SECOND;
              end else if (in_byte >= B_PRINT_LO && in_byte <= B_PRINT_HI) begin
                b[0] = in_byte;
                n    = 2'd1;
              end else begin
                ok = 1'b0;
              end
            end
            PH_SECOND: begin
              if (in_byte == B_ROW_BD || in_byte == B_ROW_BE || in_byte == B_ROW_BF) begin
                sb_step = in_byte;
                ph_step = PH_THIRD;
              end else begin
                ok = 1'b0;
              end
            end
            default: begin
              ph_step = PH_LEAD;
              n       = 2'd1;
              if (second_r == B_ROW_BF) begin
                if (in_byte == B_YEN_U8) begin
                  b[0] = B_YEN;
                end else if (in_byte == B_OVER_U8) begin
                  b[0] = B_OVER;
                end else begin
                  ok = 1'b0;
                end
              end else if (second_r == B_ROW_BD) begin
                if (in_byte >= B_KANA_LO && in_byte <= B_KANA_HI) begin
                  b[0] = in_byte;
                end else begin
                  ok = 1'b0;
                end
              end else if (second_r == B_ROW_BE) begin
                if (in_byte >= B_CONT_LO && in_byte <= B_CONT_HI) begin
                  b[0] = in_byte + B_SHIFT;
                end else begin
                  ok = 1'b0;
                end
              end else begin
                ok = 1'b0;
              end
            end
          endcase
          if (in_last && ph_step != PH_LEAD) begin
            ok = 1'b0;
          end
        end
        default: begin
          b[0] = in_byte;
          n    = 2'd1;
        end
      endcase
    end
    err_now = err_r | ~ok;
    if (err_now) begin
      n = 2'd0;
    end
  end

  always_comb begin
    res.data       = b;
    res.cnt        = n;
    res.byte_valid = 1'b1;
    res.bad        = err_now;
    res.last       = in_last;
    if (in_last && (err_now || n == 2'd0)) begin
      res.data       = '0;
      res.cnt        = 2'd1;
      res.byte_valid = 1'b0;
    end
  end

  always_comb begin
    err_nxt    = err_r;
    phase_nxt  = phase_r;
    second_nxt = second_r;
    if (fire) begin
      if (in_last) begin
        err_nxt    = 1'b0;
        phase_nxt  = PH_LEAD;
        second_nxt = 8'h00;
      end else begin
        err_nxt    = err_now;
        phase_nxt  = ph_step;
        second_nxt = sb_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r    <= 1'b0;
      phase_r  <= PH_LEAD;
      second_r <= 8'h00;
    end else begin
      err_r    <= err_nxt;
      phase_r  <= phase_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== src/jkut_emit.sv =====
// Result register: holds one item's bundle, sends a byte a cycle on out_tready.
// Loads the next bundle in the cycle that its final result is taken.
// Depends on jkut_pkg.
module jkut_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  jkut_pkg::res_t   res,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import jkut_pkg::*;

  logic [2:0][7:0] buf_r, buf_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            bytev_r, bytev_nxt;
  logic            bad_r, bad_nxt;
  logic            last_r, last_nxt;
  logic            take;

  assign take       = out_tvalid & out_tready;
  assign can_load   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[0];
  assign out_tuser  = {bad_r, bytev_r};
  assign out_tlast  = last_r && (cnt_r == 2'd1);

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    bytev_nxt = bytev_r;
    bad_nxt   = bad_r;
    last_nxt  = last_r;
    if (take) begin
      buf_nxt = {8'h00, buf_r[2], buf_r[1]};
      cnt_nxt = cnt_r - 2'd1;
    end
    if (load) begin
      buf_nxt   = res.data;
      cnt_nxt   = res.cnt;
      bytev_nxt = res.byte_valid;
      bad_nxt   = res.bad;
      last_nxt  = res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r   <= buf_nxt;
    bytev_r <= bytev_nxt;
    bad_r   <= bad_nxt;
    last_r  <= last_nxt;
  end

endmodule
